>>> rtl/euq_pkg.sv
// euq_pkg: widths, cell payload types and the arctangent table shared by the
// euler angle to unit quaternion pipeline and its cells
// depends on nothing
package euq_pkg;

    localparam int ANG_W         = 16;
    localparam int OUT_W         = 16;
    localparam int CORDIC_STEPS  = 16;
    localparam int OUT_FRAC_BITS = 14;
    localparam int ATAN_ENTRIES  = 24;
    localparam int CORDIC_N      = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;

    // rotation datapath, q30
    localparam int XY_W   = 34;
    localparam int STG_W  = $clog2(ATAN_ENTRIES);
    // cosine / sine in q16 with cordic gain
    localparam int CS_W   = XY_W - 14;
    localparam int PAIR_W = 2 * CS_W;
    localparam int TRIP_W = PAIR_W + CS_W;
    localparam int COMP_W = 32;
    localparam int MAG_W  = COMP_W - 1;
    localparam int SUM_W  = 64;
    localparam int ROOT_W = SUM_W / 2;
    localparam int RBIT_W = $clog2(ROOT_W);
    localparam int Q_W    = OUT_FRAC_BITS + 1;
    localparam int QBIT_W = $clog2(Q_W);
    localparam int DIV_W  = 64;

    localparam logic signed [XY_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [XY_W-1:0] PI_Q30      = 34'sd3373259426;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [XY_W-1:0] z;
    } t_rot;

    // one angle per lane: pitch, yaw, roll
    typedef struct packed {
        t_rot [2:0] rot;
        logic [2:0] neg;
    } t_cordic_data;

    typedef struct packed {
        logic [SUM_W-1:0]               rem;
        logic [ROOT_W-1:0]              root;
        logic [3:0][COMP_W-1:0]         comp;
    } t_sqrt_data;

    typedef struct packed {
        logic [3:0][DIV_W-1:0] rem;
        logic [3:0][Q_W-1:0]   quo;
        logic [3:0]            neg;
        logic [DIV_W-1:0]      den;
    } t_div_data;

    // atan(2^-i) in q30, truncated
    function automatic logic signed [XY_W-1:0] atan_q30(input logic [STG_W-1:0] idx);
        logic signed [XY_W-1:0] v;
        case (idx)
            0:       v = XY_W'(843314856);
            1:       v = XY_W'(497837829);
            2:       v = XY_W'(263043836);
            3:       v = XY_W'(133525158);
            4:       v = XY_W'(67021686);
            5:       v = XY_W'(33543515);
            6:       v = XY_W'(16775850);
            7:       v = XY_W'(8388437);
            8:       v = XY_W'(4194282);
            9:       v = XY_W'(2097149);
            10:      v = XY_W'(1048575);
            11:      v = XY_W'(524287);
            12:      v = XY_W'(262143);
            13:      v = XY_W'(131071);
            14:      v = XY_W'(65535);
            15:      v = XY_W'(32767);
            16:      v = XY_W'(16383);
            17:      v = XY_W'(8191);
            18:      v = XY_W'(4095);
            19:      v = XY_W'(2047);
            20:      v = XY_W'(1023);
            21:      v = XY_W'(511);
            22:      v = XY_W'(255);
            23:      v = XY_W'(127);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/euler_to_unit_quaternion_unit.sv
// euler_to_unit_quaternion_unit: top level, pitch/yaw/roll to normalized quaternion
// depends on euq_pkg, euq_cordic_cell, euq_sqrt_cell, euq_div_cell
//
// usage
//   a request is taken at every rising edge with start high; busy is always low,
//   so a new angle triple may be offered every cycle
//   angles are signed q3.13 radians, results signed q1.14 saturated to +-1
//   each result shows on o_quat_* for one cycle with o_valid high, in request
//   order, exactly one result per request
// throughput
//   one request per cycle sustained; the pipeline holds three cell chains: one
//   cordic cell per rotation step, one square root cell per root bit and one
//   divider cell per quotient bit
// reset
//   synchronous active-low reset clears every stage valid; requests in flight
//   are dropped, payload registers are left as they are
// stalls
//   the receiver cannot hold results off, so the pipeline never stops
module euler_to_unit_quaternion_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [euq_pkg::ANG_W-1:0]  i_pitch_angle,
    input  logic signed [euq_pkg::ANG_W-1:0]  i_yaw_angle,
    input  logic signed [euq_pkg::ANG_W-1:0]  i_roll_angle,
    output logic                              o_valid,
    output logic signed [euq_pkg::OUT_W-1:0]  o_quat_x,
    output logic signed [euq_pkg::OUT_W-1:0]  o_quat_y,
    output logic signed [euq_pkg::OUT_W-1:0]  o_quat_z,
    output logic signed [euq_pkg::OUT_W-1:0]  o_quat_w
);
    import euq_pkg::*;

    localparam int LATENCY = CORDIC_N + ROOT_W + Q_W + 9;

    // no backpressure anywhere, every request enters at once
    assign busy = 1'b0;

    // ---- stage 0: halve angle and fold into +-pi/2 ----
    logic         r0_valid;
    t_cordic_data r0_data;
    t_cordic_data n0_data;

    always_comb begin
        logic signed [ANG_W-1:0] ang [3];
        logic signed [XY_W-1:0]  h;
        ang[0] = i_pitch_angle;
        ang[1] = i_yaw_angle;
        ang[2] = i_roll_angle;
        n0_data = '0;
        for (int k = 0; k < 3; k++) begin
            // input times 2^16 is the half angle in q30
            h = XY_W'($signed({ang[k], 16'b0}));
            n0_data.rot[k].x = XY_W'(1) << 30;
            n0_data.rot[k].y = '0;
            n0_data.neg[k]   = 1'b0;
            if (h > HALF_PI_Q30) begin
                n0_data.rot[k].z = h - PI_Q30;
                n0_data.neg[k]   = 1'b1;
            end else if (h < -HALF_PI_Q30) begin
                n0_data.rot[k].z = h + PI_Q30;
                n0_data.neg[k]   = 1'b1;
            end else begin
                n0_data.rot[k].z = h;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else begin
            r0_valid <= start;
        end
        r0_data <= n0_data;
    end

    // ---- cordic chain, one cell per rotation step ----
    logic         cv [CORDIC_N+1];
    t_cordic_data cd [CORDIC_N+1];

    assign cv[0] = r0_valid;
    assign cd[0] = r0_data;

    for (genvar i = 0; i < CORDIC_N; i++) begin : g_cordic
        euq_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (cv[i]),
            .i_stage (STG_W'(i)),
            .i_data  (cd[i]),
            .o_valid (cv[i+1]),
            .o_data  (cd[i+1])
        );
    end

    // ---- stage 1: drop to q16 and undo the fold ----
    logic                    r1_valid;
    logic signed [CS_W-1:0]  r1_c [3];
    logic signed [CS_W-1:0]  r1_s [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= cv[CORDIC_N];
        end
        for (int k = 0; k < 3; k++) begin
            // floor shift by 14 is the upper slice
            if (cd[CORDIC_N].neg[k]) begin
                r1_c[k] <= -$signed(cd[CORDIC_N].rot[k].x[XY_W-1:14]);
                r1_s[k] <= -$signed(cd[CORDIC_N].rot[k].y[XY_W-1:14]);
            end else begin
                r1_c[k] <= $signed(cd[CORDIC_N].rot[k].x[XY_W-1:14]);
                r1_s[k] <= $signed(cd[CORDIC_N].rot[k].y[XY_W-1:14]);
            end
        end
    end

    // lanes: 0 pitch, 1 yaw, 2 roll
    // ---- stage 2: pitch by yaw products ----
    logic                     r2_valid;
    logic signed [PAIR_W-1:0] r2_cpcy, r2_spsy, r2_cpsy, r2_spcy;
    logic signed [CS_W-1:0]   r2_cr, r2_sr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
        r2_cpcy <= r1_c[0] * r1_c[1];
        r2_spsy <= r1_s[0] * r1_s[1];
        r2_cpsy <= r1_c[0] * r1_s[1];
        r2_spcy <= r1_s[0] * r1_c[1];
        r2_cr   <= r1_c[2];
        r2_sr   <= r1_s[2];
    end

    // ---- stage 3: triple products with roll ----
    logic                     r3_valid;
    logic signed [TRIP_W-1:0] r3_p [8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= r2_valid;
        end
        r3_p[0] <= r2_sr * r2_cpcy;
        r3_p[1] <= r2_cr * r2_spsy;
        r3_p[2] <= r2_cr * r2_spcy;
        r3_p[3] <= r2_sr * r2_cpsy;
        r3_p[4] <= r2_cr * r2_cpsy;
        r3_p[5] <= r2_sr * r2_spcy;
        r3_p[6] <= r2_cr * r2_cpcy;
        r3_p[7] <= r2_sr * r2_spsy;
    end

    // ---- stage 4: component sums, floor shift by 22 ----
    logic                     r4_valid;
    logic signed [COMP_W-1:0] r4_comp [4];
    logic signed [TRIP_W:0]   n4_sum  [4];

    always_comb begin
        n4_sum[0] = (TRIP_W+1)'(r3_p[0]) - (TRIP_W+1)'(r3_p[1]);
        n4_sum[1] = (TRIP_W+1)'(r3_p[2]) + (TRIP_W+1)'(r3_p[3]);
        n4_sum[2] = (TRIP_W+1)'(r3_p[4]) - (TRIP_W+1)'(r3_p[5]);
        n4_sum[3] = (TRIP_W+1)'(r3_p[6]) + (TRIP_W+1)'(r3_p[7]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else begin
            r4_valid <= r3_valid;
        end
        for (int k = 0; k < 4; k++) begin
            r4_comp[k] <= $signed(n4_sum[k][COMP_W+21:22]);
        end
    end

    // ---- stage 5: squares of the magnitudes ----
    logic                     r5_valid;
    logic [2*MAG_W-1:0]       r5_sq   [4];
    logic signed [COMP_W-1:0] r5_comp [4];

    always_ff @(posedge i_clk) begin
        logic [MAG_W-1:0] m;
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else begin
            r5_valid <= r4_valid;
        end
        for (int k = 0; k < 4; k++) begin
            m          = r4_comp[k][COMP_W-1] ? MAG_W'(-r4_comp[k]) : MAG_W'(r4_comp[k]);
            r5_sq[k]   <= m * m;
            r5_comp[k] <= r4_comp[k];
        end
    end

    // ---- stage 6: sum of squares, seeds the root chain ----
    logic       r6_valid;
    t_sqrt_data r6_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_valid <= 1'b0;
        end else begin
            r6_valid <= r5_valid;
        end
        r6_data.rem  <= SUM_W'(r5_sq[0]) + SUM_W'(r5_sq[1])
                      + SUM_W'(r5_sq[2]) + SUM_W'(r5_sq[3]);
        r6_data.root <= '0;
        for (int k = 0; k < 4; k++) begin
            r6_data.comp[k] <= r5_comp[k];
        end
    end

    // ---- square root chain, most significant root bit first ----
    logic       sv [ROOT_W+1];
    t_sqrt_data sd [ROOT_W+1];

    assign sv[0] = r6_valid;
    assign sd[0] = r6_data;

    for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
        euq_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (sv[i]),
            .i_bit   (RBIT_W'(ROOT_W - 1 - i)),
            .i_data  (sd[i]),
            .o_valid (sv[i+1]),
            .o_data  (sd[i+1])
        );
    end

    // ---- stage 7: dividend setup with rounding term ----
    logic      r7_valid;
    t_div_data r7_data;
    t_div_data n7_data;

    always_comb begin
        logic [ROOT_W-1:0]        len;
        logic signed [COMP_W-1:0] c;
        logic [MAG_W-1:0]         m;
        len          = sd[ROOT_W].root;
        n7_data      = '0;
        // zero length: x = y = z = 0 and w = 1
        n7_data.den  = (len == '0) ? DIV_W'(1) : DIV_W'(len);
        for (int k = 0; k < 4; k++) begin
            c = $signed(sd[ROOT_W].comp[k]);
            m = c[COMP_W-1] ? MAG_W'(-c) : MAG_W'(c);
            if (len == '0 && k == 3) begin
                m = MAG_W'(1);
            end
            n7_data.neg[k] = c[COMP_W-1];
            n7_data.rem[k] = (DIV_W'(m) << OUT_FRAC_BITS) + DIV_W'(len >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_valid <= 1'b0;
        end else begin
            r7_valid <= sv[ROOT_W];
        end
        r7_data <= n7_data;
    end

    // ---- divider chain, one quotient bit per cell ----
    logic      dv [Q_W+1];
    t_div_data dd [Q_W+1];

    assign dv[0] = r7_valid;
    assign dd[0] = r7_data;

    for (genvar i = 0; i < Q_W; i++) begin : g_div
        euq_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (dv[i]),
            .i_bit   (QBIT_W'(Q_W - 1 - i)),
            .i_data  (dd[i]),
            .o_valid (dv[i+1]),
            .o_data  (dd[i+1])
        );
    end

    // ---- stage 8: sign, saturation, output register ----
    localparam int LIM     = 1 << OUT_FRAC_BITS;
    localparam int OUT_MAX = (1 << (OUT_W - 1)) - 1;
    localparam int OUT_MIN = -(1 << (OUT_W - 1));

    logic                    r8_valid;
    logic signed [OUT_W-1:0] r8_q [4];
    logic signed [OUT_W-1:0] n8_q [4];

    always_comb begin
        logic signed [Q_W+1:0] v;
        for (int k = 0; k < 4; k++) begin
            v = $signed({2'b00, dd[Q_W].quo[k]});
            if (dd[Q_W].neg[k]) begin
                v = -v;
            end
            if (v > LIM) begin
                v = (Q_W+2)'(LIM);
            end
            if (v < -LIM) begin
                v = -(Q_W+2)'(LIM);
            end
            if (v > OUT_MAX) begin
                n8_q[k] = OUT_W'(OUT_MAX);
            end else if (v < OUT_MIN) begin
                n8_q[k] = OUT_W'(OUT_MIN);
            end else begin
                n8_q[k] = OUT_W'(v);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_valid <= 1'b0;
        end else begin
            r8_valid <= dv[Q_W];
        end
        for (int k = 0; k < 4; k++) begin
            r8_q[k] <= n8_q[k];
        end
    end

    assign o_valid  = r8_valid;
    assign o_quat_x = r8_q[0];
    assign o_quat_y = r8_q[1];
    assign o_quat_z = r8_q[2];
    assign o_quat_w = r8_q[3];

`ifndef NO_ASSERTIONS
    // every result traces back to a matching earlier request
    a_result_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LATENCY))
        else $error("result without matching request");

    // the divider never sees a zero divisor
    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r7_valid |-> (r7_data.den != '0))
        else $error("zero divisor entered divider chain");

    // normalized x and w components stay within plus or minus one
    a_x_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_quat_x <= LIM && o_quat_x >= -LIM))
        else $error("quat_x out of range");

    a_w_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_quat_w <= LIM && o_quat_w >= -LIM))
        else $error("quat_w out of range");
`endif
endmodule

>>> rtl/euq_cordic_cell.sv
// euq_cordic_cell: one rotation step for the three half angles
// depends on euq_pkg
module euq_cordic_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [euq_pkg::STG_W-1:0]  i_stage,
    input  euq_pkg::t_cordic_data      i_data,
    output logic                       o_valid,
    output euq_pkg::t_cordic_data      o_data
);
    import euq_pkg::*;

    logic         r_valid;
    t_cordic_data r_data;
    t_cordic_data n_data;

    always_comb begin
        logic signed [XY_W-1:0] x, y, z, dx, dy, a;
        n_data     = i_data;
        a          = atan_q30(i_stage);
        for (int k = 0; k < 3; k++) begin
            x  = i_data.rot[k].x;
            y  = i_data.rot[k].y;
            z  = i_data.rot[k].z;
            dx = y >>> i_stage;
            dy = x >>> i_stage;
            if (!z[XY_W-1]) begin
                n_data.rot[k].x = x - dx;
                n_data.rot[k].y = y + dy;
                n_data.rot[k].z = z - a;
            end else begin
                n_data.rot[k].x = x + dx;
                n_data.rot[k].y = y - dy;
                n_data.rot[k].z = z + a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

>>> rtl/euq_sqrt_cell.sv
// euq_sqrt_cell: one result bit of the integer square root, components ride along
// depends on euq_pkg
module euq_sqrt_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [euq_pkg::RBIT_W-1:0]  i_bit,
    input  euq_pkg::t_sqrt_data         i_data,
    output logic                        o_valid,
    output euq_pkg::t_sqrt_data         o_data
);
    import euq_pkg::*;

    logic       r_valid;
    t_sqrt_data r_data;
    t_sqrt_data n_data;

    always_comb begin
        logic [SUM_W+1:0] trial;
        logic [SUM_W+1:0] rem_ext;
        n_data  = i_data;
        // (root + 2^k)^2 - root^2
        trial   = ({2'b00, SUM_W'(i_data.root)} << ({1'b0, i_bit} + 1'b1))
                + ((SUM_W+2)'(1) << {i_bit, 1'b0});
        rem_ext = {2'b00, i_data.rem};
        if (rem_ext >= trial) begin
            n_data.rem  = SUM_W'(rem_ext - trial);
            n_data.root = i_data.root | (ROOT_W'(1) << i_bit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

>>> rtl/euq_div_cell.sv
// euq_div_cell: one quotient bit of the four restoring divisions
// depends on euq_pkg
module euq_div_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [euq_pkg::QBIT_W-1:0]  i_bit,
    input  euq_pkg::t_div_data          i_data,
    output logic                        o_valid,
    output euq_pkg::t_div_data          o_data
);
    import euq_pkg::*;

    logic      r_valid;
    t_div_data r_data;
    t_div_data n_data;

    always_comb begin
        logic [DIV_W-1:0] trial;
        n_data = i_data;
        trial  = i_data.den << i_bit;
        for (int k = 0; k < 4; k++) begin
            if (i_data.rem[k] >= trial) begin
                n_data.rem[k] = i_data.rem[k] - trial;
                n_data.quo[k] = i_data.quo[k] | (Q_W'(1) << i_bit);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

>>> verif/euler_to_unit_quaternion_unit_test.sv
// euler_to_unit_quaternion_unit_test: self-checking bench for the angle to quaternion unit
// depends on euq_pkg and euler_to_unit_quaternion_unit; predicts every result with an
// integer cordic, square root and divider of its own
module euler_to_unit_quaternion_unit_test;
    import euq_pkg::*;

    localparam int N_DIRECTED = 14;
    localparam int N_RANDOM   = 1550;
    localparam int LATENCY    = CORDIC_N + ROOT_W + Q_W + 9;
    localparam longint LIM    = 64'sd1 << OUT_FRAC_BITS;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic signed [15:0] w;
    } t_quat;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [15:0] i_pitch_angle = '0;
    logic signed [15:0] i_yaw_angle = '0;
    logic signed [15:0] i_roll_angle = '0;
    logic               o_valid;
    logic signed [15:0] o_quat_x, o_quat_y, o_quat_z, o_quat_w;

    t_quat  quat_queue[$];
    int     errors = 0;
    int     results_seen = 0;
    int     requests_sent = 0;

    // directed rows: pitch, yaw, roll, expected-known flag, expected quaternion
    logic signed [15:0] dir_ang[N_DIRECTED][3];
    logic               dir_known[N_DIRECTED];
    t_quat              dir_quat[N_DIRECTED];

    euler_to_unit_quaternion_unit i_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #50_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    // cosine and sine in q16 with the cordic gain, from a q30 half angle
    function automatic void half_angle_cs(longint h, output longint c, output longint s);
        longint x, y, z, dx, dy;
        bit     flip;
        x = 64'sd1 << 30;
        y = 0;
        flip = 1'b0;
        // fold into [-pi/2, pi/2]
        if (h > 64'sd1686629713) begin
            h = h - 64'sd3373259426;
            flip = 1'b1;
        end else if (h < -64'sd1686629713) begin
            h = h + 64'sd3373259426;
            flip = 1'b1;
        end
        z = h;
        for (int i = 0; i < CORDIC_N; i++) begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(atan_q30(STG_W'(i)));
            end else begin
                x += dx; y -= dy; z += longint'(atan_q30(STG_W'(i)));
            end
        end
        c = floor_shr(x, 14);
        s = floor_shr(y, 14);
        if (flip) begin
            c = -c;
            s = -s;
        end
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic logic signed [15:0] scale_component(longint c, longint unsigned len);
        longint unsigned mag;
        longint q;
        mag = (c < 0) ? longint'(-c) : longint'(c);
        q = longint'(((mag << OUT_FRAC_BITS) + (len >> 1)) / len);
        if (c < 0) q = -q;
        if (q > LIM) q = LIM;
        if (q < -LIM) q = -LIM;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q[15:0];
    endfunction

    function automatic t_quat predict_quat(logic signed [15:0] p, logic signed [15:0] yw,
                                           logic signed [15:0] r);
        longint cp, sp, cy, sy, cr, sr;
        longint comp[4];
        longint unsigned sum, len, m;
        t_quat q;
        half_angle_cs(longint'(p) * 65536, cp, sp);
        half_angle_cs(longint'(yw) * 65536, cy, sy);
        half_angle_cs(longint'(r) * 65536, cr, sr);
        comp[0] = floor_shr(sr * cp * cy - cr * sp * sy, 22);
        comp[1] = floor_shr(cr * sp * cy + sr * cp * sy, 22);
        comp[2] = floor_shr(cr * cp * sy - sr * sp * cy, 22);
        comp[3] = floor_shr(cr * cp * cy + sr * sp * sy, 22);
        sum = 0;
        for (int k = 0; k < 4; k++) begin
            m = (comp[k] < 0) ? longint'(-comp[k]) : longint'(comp[k]);
            sum += m * m;
        end
        len = root_floor(sum);
        if (len == 0) begin
            // degenerate length: identity rotation
            q.x = '0; q.y = '0; q.z = '0;
            q.w = scale_component(1, 1);
        end else begin
            q.x = scale_component(comp[0], len);
            q.y = scale_component(comp[1], len);
            q.z = scale_component(comp[2], len);
            q.w = scale_component(comp[3], len);
        end
        return q;
    endfunction

    // random gap: mostly none or short, now and then long
    task automatic idle_gap();
        int n;
        n = $urandom_range(0, 99);
        if (n < 55) n = 0;
        else if (n < 92) n = $urandom_range(1, 3);
        else n = $urandom_range(10, 90);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // drive one request and hold it until the unit takes it
    task automatic send_request(logic signed [15:0] p, logic signed [15:0] yw,
                                logic signed [15:0] r, logic known, t_quat want);
        t_quat q;
        q = predict_quat(p, yw, r);
        if (known && q !== want) begin
            $error("predictor disagrees on row p=%0d y=%0d r=%0d: want %h got %h",
                   p, yw, r, want, q);
            errors++;
        end
        start <= 1'b1;
        i_pitch_angle <= p;
        i_yaw_angle <= yw;
        i_roll_angle <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        quat_queue.push_back(known ? want : q);
        requests_sent++;
    endtask

    // angle with random fill, biased toward the fold boundaries and extremes
    function automatic logic signed [15:0] pick_angle();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0:       return 16'sh7fff - 16'($urandom_range(0, 3));
            1:       return 16'sh8000 + 16'($urandom_range(0, 3));
            // pi in q3.13 is about 25736, where the half angle folds
            2:       return 16'(25736 + $urandom_range(0, 8) - 4);
            3:       return 16'(-25736 + $urandom_range(0, 8) - 4);
            4:       return 16'($urandom_range(0, 16) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    // result checker: the unit cannot be stalled, so every strobe is a result
    always @(posedge i_clk) begin
        t_quat want;
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (quat_queue.size() == 0) begin
                $error("unexpected result x=%0d y=%0d z=%0d w=%0d",
                       o_quat_x, o_quat_y, o_quat_z, o_quat_w);
                errors++;
            end else begin
                want = quat_queue.pop_front();
                if (o_quat_x !== want.x) begin
                    $error("quat_x expected %0d actual %0d", want.x, o_quat_x);
                    errors++;
                end
                if (o_quat_y !== want.y) begin
                    $error("quat_y expected %0d actual %0d", want.y, o_quat_y);
                    errors++;
                end
                if (o_quat_z !== want.z) begin
                    $error("quat_z expected %0d actual %0d", want.z, o_quat_z);
                    errors++;
                end
                if (o_quat_w !== want.w) begin
                    $error("quat_w expected %0d actual %0d", want.w, o_quat_w);
                    errors++;
                end
            end
        end
    end

    initial begin
        int wait_cycles;
        // directed table; zero angles give the identity, which reads off directly
        dir_ang[0]  = '{16'sd0, 16'sd0, 16'sd0};
        dir_ang[1]  = '{16'sh7fff, 16'sh7fff, 16'sh7fff};
        dir_ang[2]  = '{16'sh8000, 16'sh8000, 16'sh8000};
        dir_ang[3]  = '{16'sh7fff, 16'sh8000, 16'sd0};
        dir_ang[4]  = '{16'sd0, 16'sh7fff, 16'sh8000};
        dir_ang[5]  = '{16'sd25736, 16'sd0, 16'sd0};
        dir_ang[6]  = '{16'sd0, 16'sd25737, 16'sd0};
        dir_ang[7]  = '{16'sd0, 16'sd0, -16'sd25737};
        dir_ang[8]  = '{16'sd12868, 16'sd12868, 16'sd12868};
        dir_ang[9]  = '{-16'sd12868, 16'sd6434, -16'sd1};
        dir_ang[10] = '{16'sd1, -16'sd1, 16'sd1};
        dir_ang[11] = '{16'sh5555, 16'shaaaa, 16'sh5555};
        dir_ang[12] = '{16'shaaaa, 16'sh5555, 16'shaaaa};
        dir_ang[13] = '{-16'sd25736, -16'sd25736, 16'sd25736};
        for (int i = 0; i < N_DIRECTED; i++) begin
            dir_known[i] = 1'b0;
            dir_quat[i] = '0;
        end
        dir_known[0] = 1'b1;
        dir_quat[0] = '{x: 16'sd0, y: 16'sd0, z: 16'sd0, w: 16'sd16384};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            send_request(dir_ang[i][0], dir_ang[i][1], dir_ang[i][2], dir_known[i],
                         dir_quat[i]);
            if (i % 4 == 3) idle_gap();
        end

        for (int i = 0; i < N_RANDOM; i++) begin
            // bursts with no gaps at all now and then
            if ((i / 100) % 3 != 1) idle_gap();
            send_request(pick_angle(), pick_angle(), pick_angle(), 1'b0, '0);
        end
        start <= 1'b0;

        wait_cycles = 0;
        while (quat_queue.size() != 0 && wait_cycles < 20 * LATENCY) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (2 * LATENCY) @(posedge i_clk);

        $display("covered %0d angle triples, %0d quaternions compared", requests_sent,
                 results_seen);
        if (errors == 0 && quat_queue.size() == 0) begin
            $display("No mismatches found");
        end else begin
            if (quat_queue.size() != 0)
                $error("%0d results never arrived", quat_queue.size());
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> euler_to_unit_quaternion_unit.f
rtl/euq_pkg.sv
rtl/euq_cordic_cell.sv
rtl/euq_sqrt_cell.sv
rtl/euq_div_cell.sv
rtl/euler_to_unit_quaternion_unit.sv
verif/euler_to_unit_quaternion_unit_test.sv
